[sv/video_dot_timing_scroll_regs_defines.svh]
// Assertion macros for the dot timing and scroll register block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef VIDEO_DOT_TIMING_SCROLL_REGS_DEFINES_SVH
`define VIDEO_DOT_TIMING_SCROLL_REGS_DEFINES_SVH

`ifndef SYNTH

`define VDTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vdts assertion failed");

`define VDTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdts assertion failed");

`else

`define VDTS_ASSERT(lbl, prop)

`define VDTS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[sv/vdts_pkg.sv]
package vdts_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam int DOTS_PER_LINE   = 341;
  localparam int LINES_PER_FRAME = 262;

  localparam logic [8:0] DOT_MAX       = 9'(DOTS_PER_LINE - 1);
  localparam logic [8:0] DOT_SKIP      = 9'(DOTS_PER_LINE - 2);
  localparam logic [8:0] LINE_PRE      = 9'(LINES_PER_FRAME - 1);
  localparam logic [8:0] LINE_VIS_END  = 9'd240;
  localparam logic [8:0] LINE_VBLANK   = 9'd241;
  localparam logic [8:0] DOT_FETCH_END = 9'd256;
  localparam logic [8:0] DOT_HCOPY     = 9'd257;
  localparam logic [8:0] DOT_VCOPY_LO  = 9'd280;
  localparam logic [8:0] DOT_VCOPY_HI  = 9'd304;
  localparam logic [8:0] DOT_PREF_LO   = 9'd321;
  localparam logic [8:0] DOT_PREF_HI   = 9'd336;

  localparam logic [4:0] NMI_DELAY_RST = 5'd15;
  localparam logic [8:0] DOT_RST       = 9'd340;
  localparam logic [8:0] LINE_RST      = 9'd240;

  localparam logic [4:0] COARSE_MAX    = 5'd31;
  localparam logic [4:0] COARSE_Y_LAST = 5'd29;

  localparam int OUT_W = 48;

endpackage

[sv/video_dot_timing_scroll_regs.sv]
// Dot and scanline timing plus loopy scroll registers of a NES-style picture unit.
// Input channel in_*: one request per dot tick or CPU register access.
//   in_tuser holds cmd (tick, write, read, none) and the register offset,
//   in_tdata holds the write byte and the sprite zero / overflow flags.
// Output channel out_*: exactly one result per request, carrying the status
//   byte, v, fine x, dot, line, frame parity, the NMI pulse and rendering_on.
// cfg_wr_en / cfg_wr_data load the NMI delay (ticks from the NMI condition
//   rising to the pulse); write it only while no request is in flight.
// Each accepted result is registered in the output or, if held, the skid register;
//   one request is taken every cycle while in_tready is high (combinational update).
// The result sits in an output register backed by a one-entry skid register;
//   in_tready is low only while the skid register holds a result, so a stalled
//   receiver costs at most one more accepted request before input stops.
// Reset (rst_n low, synchronous) puts the counters at dot 340 of line 240,
//   clears the scroll registers and flags, sets the NMI delay to 15 and
//   empties both result registers.
`include "video_dot_timing_scroll_regs_defines.svh"

module video_dot_timing_scroll_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // wdata[7:0], sprite_zero_in[8], overflow_in[9], zero
  input  logic [4:0]  in_tuser,   // cmd[1:0], reg_index[4:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // rdata[7:0], vram_addr[23:8], fine_scroll_x[26:24],
                                  // dot[35:27], line[44:36], odd_frame[45],
                                  // nmi_pulse[46], rendering_on[47]
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  function automatic logic [15:0] coarse_x_inc(input logic [15:0] v);
    logic [15:0] r;
    if (v[4:0] == vdts_pkg::COARSE_MAX) begin
      r = {v[15:11], ~v[10], v[9:5], 5'd0};
    end else begin
      r = v + 16'd1;
    end
    return r;
  endfunction

  function automatic logic [15:0] fine_y_inc(input logic [15:0] v);
    logic [15:0] r;
    logic [4:0]  cy;
    r  = v;
    cy = v[9:5];
    if (v[14:12] != 3'b111) begin
      r = v + 16'h1000;
    end else begin
      r[14:12] = 3'b000;
      if (cy == vdts_pkg::COARSE_Y_LAST) begin
        cy    = 5'd0;
        r[11] = ~r[11];
      end else if (cy == vdts_pkg::COARSE_MAX) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r[9:5] = cy;
    end
    return r;
  endfunction

  logic [4:0]  nmi_delay_r;
  logic [8:0]  dot_r, dot_nxt;
  logic [8:0]  line_r, line_nxt;
  logic        frame_parity_r, frame_parity_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [15:0] tmp_addr_r, tmp_addr_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic        write_toggle_r, write_toggle_nxt;
  logic        bg_enable_r, bg_enable_nxt;
  logic        spr_enable_r, spr_enable_nxt;
  logic        inc_by_32_r, inc_by_32_nxt;
  logic        nmi_enable_r, nmi_enable_nxt;
  logic        vblank_r, vblank_nxt;
  logic        nmi_prev_r, nmi_prev_nxt;
  logic [4:0]  nmi_countdown_r, nmi_countdown_nxt;
  logic [4:0]  last_low_r, last_low_nxt;
  logic        spr0_flag_r, spr0_flag_nxt;
  logic        ovf_flag_r, ovf_flag_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic [47:0] skid_data_r, skid_data_nxt;

  vdts_pkg::cmd_t cmd;
  logic [2:0]  reg_idx;
  logic [7:0]  wdata;
  logic        spr0_in;
  logic        ovf_in;
  logic        in_acc;
  logic        out_free;
  logic        render;
  logic        render_line;
  logic        fetch_dot;
  logic        skip;
  logic        nmi_cond;
  logic [9:0]  dot_inc;
  logic [9:0]  line_inc;
  logic [15:0] v_work;
  logic [15:0] t_work;
  logic [15:0] addr_step;
  logic [7:0]  rdata;
  logic        pulse;
  logic [47:0] result;

  assign cmd      = vdts_pkg::cmd_t'(in_tuser[1:0]);
  assign reg_idx  = in_tuser[4:2];
  assign wdata    = in_tdata[7:0];
  assign spr0_in  = in_tdata[8];
  assign ovf_in   = in_tdata[9];
  assign in_tready = !skid_valid_r;
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign render   = bg_enable_r || spr_enable_r;
  assign dot_inc  = {1'b0, dot_r} + 10'd1;
  assign line_inc = {1'b0, line_r} + 10'd1;
  assign addr_step = cur_addr_r + (inc_by_32_r ? 16'd32 : 16'd1);
  assign skip = render && frame_parity_r && (line_r == vdts_pkg::LINE_PRE) &&
                (dot_r == vdts_pkg::DOT_SKIP);

  always_comb begin
    dot_nxt           = dot_r;
    line_nxt          = line_r;
    frame_parity_nxt  = frame_parity_r;
    cur_addr_nxt      = cur_addr_r;
    tmp_addr_nxt      = tmp_addr_r;
    fine_x_nxt        = fine_x_r;
    write_toggle_nxt  = write_toggle_r;
    bg_enable_nxt     = bg_enable_r;
    spr_enable_nxt    = spr_enable_r;
    inc_by_32_nxt     = inc_by_32_r;
    nmi_enable_nxt    = nmi_enable_r;
    vblank_nxt        = vblank_r;
    nmi_prev_nxt      = nmi_prev_r;
    nmi_countdown_nxt = nmi_countdown_r;
    last_low_nxt      = last_low_r;
    spr0_flag_nxt     = spr0_flag_r;
    ovf_flag_nxt      = ovf_flag_r;
    rdata             = 8'd0;
    pulse             = 1'b0;
    nmi_cond          = 1'b0;
    render_line       = 1'b0;
    fetch_dot         = 1'b0;
    v_work            = cur_addr_r;
    t_work            = tmp_addr_r;

    unique case (cmd)
      vdts_pkg::CMD_TICK: begin
        if (nmi_countdown_r != 5'd0) begin
          nmi_countdown_nxt = nmi_countdown_r - 5'd1;
          pulse = (nmi_countdown_r == 5'd1) && nmi_enable_r && vblank_r;
        end
        if (skip) begin
          dot_nxt          = 9'd0;
          line_nxt         = 9'd0;
          frame_parity_nxt = ~frame_parity_r;
        end else if (dot_inc > {1'b0, vdts_pkg::DOT_MAX}) begin
          dot_nxt = 9'd0;
          if (line_inc > {1'b0, vdts_pkg::LINE_PRE}) begin
            line_nxt         = 9'd0;
            frame_parity_nxt = ~frame_parity_r;
          end else begin
            line_nxt = line_inc[8:0];
          end
        end else begin
          dot_nxt = dot_inc[8:0];
        end

        render_line = (line_nxt == vdts_pkg::LINE_PRE) ||
                      (line_nxt < vdts_pkg::LINE_VIS_END);
        fetch_dot = ((dot_nxt >= 9'd1) && (dot_nxt <= vdts_pkg::DOT_FETCH_END)) ||
                    ((dot_nxt >= vdts_pkg::DOT_PREF_LO) &&
                     (dot_nxt <= vdts_pkg::DOT_PREF_HI));

        if (render) begin
          if ((line_nxt == vdts_pkg::LINE_PRE) && (dot_nxt >= vdts_pkg::DOT_VCOPY_LO) &&
              (dot_nxt <= vdts_pkg::DOT_VCOPY_HI)) begin
            v_work[14:11] = tmp_addr_r[14:11];
            v_work[9:5]   = tmp_addr_r[9:5];
          end
          if (render_line) begin
            if (fetch_dot && (dot_nxt[2:0] == 3'd0)) begin
              v_work = coarse_x_inc(v_work);
            end
            if (dot_nxt == vdts_pkg::DOT_FETCH_END) begin
              v_work = fine_y_inc(v_work);
            end
            if (dot_nxt == vdts_pkg::DOT_HCOPY) begin
              v_work[10]  = tmp_addr_r[10];
              v_work[4:0] = tmp_addr_r[4:0];
            end
          end
        end
        cur_addr_nxt = v_work;

        if (spr0_in) spr0_flag_nxt = 1'b1;
        if (ovf_in) ovf_flag_nxt = 1'b1;

        if ((line_nxt == vdts_pkg::LINE_VBLANK) && (dot_nxt == 9'd1)) begin
          vblank_nxt = 1'b1;
          nmi_cond   = nmi_enable_r;
          if (nmi_cond && !nmi_prev_r) nmi_countdown_nxt = nmi_delay_r;
          nmi_prev_nxt = nmi_cond;
        end
        if ((line_nxt == vdts_pkg::LINE_PRE) && (dot_nxt == 9'd1)) begin
          vblank_nxt    = 1'b0;
          nmi_prev_nxt  = 1'b0;
          spr0_flag_nxt = 1'b0;
          ovf_flag_nxt  = 1'b0;
        end
      end

      vdts_pkg::CMD_WRITE: begin
        last_low_nxt = wdata[4:0];
        unique case (reg_idx)
          vdts_pkg::REG_CTRL: begin
            inc_by_32_nxt  = wdata[2];
            nmi_enable_nxt = wdata[7];
            nmi_cond       = wdata[7] && vblank_r;
            if (nmi_cond && !nmi_prev_r) nmi_countdown_nxt = nmi_delay_r;
            nmi_prev_nxt   = nmi_cond;
            t_work[11:10]  = wdata[1:0];
          end
          vdts_pkg::REG_MASK: begin
            bg_enable_nxt  = wdata[3];
            spr_enable_nxt = wdata[4];
          end
          vdts_pkg::REG_SCROLL: begin
            if (!write_toggle_r) begin
              t_work[4:0] = wdata[7:3];
              fine_x_nxt  = wdata[2:0];
            end else begin
              t_work[14:12] = wdata[2:0];
              t_work[9:5]   = wdata[7:3];
            end
            write_toggle_nxt = !write_toggle_r;
          end
          vdts_pkg::REG_ADDR: begin
            if (!write_toggle_r) begin
              t_work[14]   = 1'b0;
              t_work[13:8] = wdata[5:0];
            end else begin
              t_work[7:0]  = wdata;
              cur_addr_nxt = t_work;
            end
            write_toggle_nxt = !write_toggle_r;
          end
          vdts_pkg::REG_DATA: begin
            cur_addr_nxt = addr_step;
          end
          default: begin
          end
        endcase
        tmp_addr_nxt = t_work;
      end

      vdts_pkg::CMD_READ: begin
        if (reg_idx == vdts_pkg::REG_STATUS) begin
          rdata            = {vblank_r, spr0_flag_r, ovf_flag_r, last_low_r};
          vblank_nxt       = 1'b0;
          nmi_prev_nxt     = 1'b0;
          write_toggle_nxt = 1'b0;
        end else if (reg_idx == vdts_pkg::REG_DATA) begin
          cur_addr_nxt = addr_step;
        end
      end

      vdts_pkg::CMD_NONE: begin
      end
    endcase

    result = {bg_enable_nxt || spr_enable_nxt, pulse, frame_parity_nxt, line_nxt,
              dot_nxt, fine_x_nxt, cur_addr_nxt, rdata};
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (in_acc) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end else if (out_free) begin
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nmi_delay_r     <= vdts_pkg::NMI_DELAY_RST;
      dot_r           <= vdts_pkg::DOT_RST;
      line_r          <= vdts_pkg::LINE_RST;
      frame_parity_r  <= 1'b0;
      cur_addr_r      <= 16'd0;
      tmp_addr_r      <= 16'd0;
      fine_x_r        <= 3'd0;
      write_toggle_r  <= 1'b0;
      bg_enable_r     <= 1'b0;
      spr_enable_r    <= 1'b0;
      inc_by_32_r     <= 1'b0;
      nmi_enable_r    <= 1'b0;
      vblank_r        <= 1'b0;
      nmi_prev_r      <= 1'b0;
      nmi_countdown_r <= 5'd0;
      last_low_r      <= 5'd0;
      spr0_flag_r     <= 1'b0;
      ovf_flag_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) nmi_delay_r <= cfg_wr_data;
      if (in_acc) begin
        dot_r           <= dot_nxt;
        line_r          <= line_nxt;
        frame_parity_r  <= frame_parity_nxt;
        cur_addr_r      <= cur_addr_nxt;
        tmp_addr_r      <= tmp_addr_nxt;
        fine_x_r        <= fine_x_nxt;
        write_toggle_r  <= write_toggle_nxt;
        bg_enable_r     <= bg_enable_nxt;
        spr_enable_r    <= spr_enable_nxt;
        inc_by_32_r     <= inc_by_32_nxt;
        nmi_enable_r    <= nmi_enable_nxt;
        vblank_r        <= vblank_nxt;
        nmi_prev_r      <= nmi_prev_nxt;
        nmi_countdown_r <= nmi_countdown_nxt;
        last_low_r      <= last_low_nxt;
        spr0_flag_r     <= spr0_flag_nxt;
        ovf_flag_r      <= ovf_flag_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `VDTS_ASSERT(a_counter_range, (dot_r <= vdts_pkg::DOT_MAX) && (line_r <= vdts_pkg::LINE_PRE))
  `VDTS_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r)
  `VDTS_ASSERT_NEXT(a_frame_wrap,
    in_acc && (cmd == vdts_pkg::CMD_TICK) && (dot_r == vdts_pkg::DOT_MAX) &&
    (line_r == vdts_pkg::LINE_PRE),
    (dot_r == 9'd0) && (line_r == 9'd0) && (frame_parity_r != $past(frame_parity_r)))
  `VDTS_ASSERT_NEXT(a_status_clears_toggle,
    in_acc && (cmd == vdts_pkg::CMD_READ) && (reg_idx == vdts_pkg::REG_STATUS),
    !write_toggle_r && !vblank_r)

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MIX_CHUNK = 150;
  localparam int SWEEP_ITEMS = 100;

  typedef struct {
    vdts_pkg::cmd_t cmd;
    logic [2:0] idx;
    logic [7:0] wdata;
    logic       spr0;
    logic       ovf;
  } request_t;

  typedef struct packed {
    logic       rendering_on;
    logic       nmi_pulse;
    logic       odd_frame;
    logic [8:0] line;
    logic [8:0] dot;
    logic [2:0] fine_x;
    logic [15:0] vram_addr;
    logic [7:0] rdata;
  } dot_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [47:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  video_dot_timing_scroll_regs dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  dot_status_t expected_status[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;

  logic [4:0]  nmi_delay_q;
  logic [8:0]  pos_dot, pos_line;
  logic        frame_odd;
  logic [15:0] v_addr, t_addr;
  logic [2:0]  x_fine;
  logic        toggle_w, show_bg, show_spr, step32, nmi_en;
  logic        in_vblank, nmi_level, hit_flag, ovf_flag;
  logic [4:0]  nmi_timer, low_bits;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_model();
    nmi_delay_q = vdts_pkg::NMI_DELAY_RST;
    pos_dot = vdts_pkg::DOT_RST;
    pos_line = vdts_pkg::LINE_RST;
    frame_odd = 1'b0;
    v_addr = '0;
    t_addr = '0;
    x_fine = '0;
    toggle_w = 1'b0;
    show_bg = 1'b0;
    show_spr = 1'b0;
    step32 = 1'b0;
    nmi_en = 1'b0;
    in_vblank = 1'b0;
    nmi_level = 1'b0;
    nmi_timer = '0;
    low_bits = '0;
    hit_flag = 1'b0;
    ovf_flag = 1'b0;
  endfunction

  function automatic void track_nmi_level();
    logic level;
    level = nmi_en & in_vblank;
    if (level && !nmi_level)
      nmi_timer = nmi_delay_q;
    nmi_level = level;
  endfunction

  function automatic void bump_coarse_x();
    if (v_addr[4:0] == vdts_pkg::COARSE_MAX)
      v_addr = {v_addr[15:11], ~v_addr[10], v_addr[9:5], 5'd0};
    else
      v_addr = v_addr + 16'd1;
  endfunction

  function automatic void bump_fine_y();
    logic [4:0] cy;
    if (v_addr[14:12] != 3'h7) begin
      v_addr = v_addr + 16'h1000;
    end else begin
      v_addr[14:12] = 3'h0;
      cy = v_addr[9:5];
      if (cy == vdts_pkg::COARSE_Y_LAST) begin
        cy = 5'd0;
        v_addr[11] = ~v_addr[11];
      end else if (cy == vdts_pkg::COARSE_MAX) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      v_addr[9:5] = cy;
    end
  endfunction

  function automatic void step_data_addr();
    v_addr = v_addr + (step32 ? 16'd32 : 16'd1);
  endfunction

  function automatic logic advance_dot(input logic spr0, input logic ovf);
    logic pulse, rendering, on_line, fetch;
    pulse = 1'b0;
    rendering = show_bg | show_spr;
    if (nmi_timer != 0) begin
      nmi_timer = nmi_timer - 5'd1;
      if (nmi_timer == 0 && nmi_en && in_vblank)
        pulse = 1'b1;
    end
    if (rendering && frame_odd && pos_line == vdts_pkg::LINE_PRE &&
        pos_dot == vdts_pkg::DOT_SKIP) begin
      pos_dot = '0;
      pos_line = '0;
      frame_odd = ~frame_odd;
    end else if (pos_dot >= vdts_pkg::DOT_MAX) begin
      pos_dot = '0;
      if (pos_line >= vdts_pkg::LINE_PRE) begin
        pos_line = '0;
        frame_odd = ~frame_odd;
      end else begin
        pos_line = pos_line + 9'd1;
      end
    end else begin
      pos_dot = pos_dot + 9'd1;
    end

    on_line = (pos_line == vdts_pkg::LINE_PRE) || (pos_line < vdts_pkg::LINE_VIS_END);
    fetch = (pos_dot >= 9'd1 && pos_dot <= vdts_pkg::DOT_FETCH_END) ||
            (pos_dot >= vdts_pkg::DOT_PREF_LO && pos_dot <= vdts_pkg::DOT_PREF_HI);
    if (rendering) begin
      if (pos_line == vdts_pkg::LINE_PRE && pos_dot >= vdts_pkg::DOT_VCOPY_LO &&
          pos_dot <= vdts_pkg::DOT_VCOPY_HI)
        v_addr = {v_addr[15], t_addr[14:11], v_addr[10], t_addr[9:5], v_addr[4:0]};
      if (on_line) begin
        if (fetch && pos_dot[2:0] == 3'd0)
          bump_coarse_x();
        if (pos_dot == vdts_pkg::DOT_FETCH_END)
          bump_fine_y();
        if (pos_dot == vdts_pkg::DOT_HCOPY)
          v_addr = {v_addr[15:11], t_addr[10], v_addr[9:5], t_addr[4:0]};
      end
    end

    if (spr0)
      hit_flag = 1'b1;
    if (ovf)
      ovf_flag = 1'b1;
    if (pos_line == vdts_pkg::LINE_VBLANK && pos_dot == 9'd1) begin
      in_vblank = 1'b1;
      track_nmi_level();
    end
    if (pos_line == vdts_pkg::LINE_PRE && pos_dot == 9'd1) begin
      in_vblank = 1'b0;
      track_nmi_level();
      hit_flag = 1'b0;
      ovf_flag = 1'b0;
    end
    return pulse;
  endfunction

  function automatic void write_register(input logic [2:0] idx, input logic [7:0] d);
    low_bits = d[4:0];
    case (idx)
      vdts_pkg::REG_CTRL: begin
        step32 = d[2];
        nmi_en = d[7];
        track_nmi_level();
        t_addr[11:10] = d[1:0];
      end
      vdts_pkg::REG_MASK: begin
        show_bg = d[3];
        show_spr = d[4];
      end
      vdts_pkg::REG_SCROLL: begin
        if (!toggle_w) begin
          t_addr[4:0] = d[7:3];
          x_fine = d[2:0];
          toggle_w = 1'b1;
        end else begin
          t_addr[14:12] = d[2:0];
          t_addr[9:5] = d[7:3];
          toggle_w = 1'b0;
        end
      end
      vdts_pkg::REG_ADDR: begin
        if (!toggle_w) begin
          t_addr[14:8] = {1'b0, d[5:0]};
          toggle_w = 1'b1;
        end else begin
          t_addr[7:0] = d;
          v_addr = t_addr;
          toggle_w = 1'b0;
        end
      end
      vdts_pkg::REG_DATA: step_data_addr();
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] read_register(input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx == vdts_pkg::REG_STATUS) begin
      r = {in_vblank, hit_flag, ovf_flag, low_bits};
      in_vblank = 1'b0;
      track_nmi_level();
      toggle_w = 1'b0;
    end else if (idx == vdts_pkg::REG_DATA) begin
      step_data_addr();
    end
    return r;
  endfunction

  function automatic void predict_status(input request_t r);
    dot_status_t e;
    e = '0;
    case (r.cmd)
      vdts_pkg::CMD_TICK:  e.nmi_pulse = advance_dot(r.spr0, r.ovf);
      vdts_pkg::CMD_WRITE: write_register(r.idx, r.wdata);
      vdts_pkg::CMD_READ:  e.rdata = read_register(r.idx);
      default: ;
    endcase
    e.vram_addr = v_addr;
    e.fine_x = x_fine;
    e.dot = pos_dot;
    e.line = pos_line;
    e.odd_frame = frame_odd;
    e.rendering_on = show_bg | show_spr;
    expected_status.push_back(e);
  endfunction

  function automatic request_t make_request(input vdts_pkg::cmd_t cmd,
                                            input logic [2:0] idx,
                                            input logic [7:0] wdata, input logic spr0,
                                            input logic ovf);
    request_t r;
    r.cmd = cmd;
    r.idx = idx;
    r.wdata = wdata;
    r.spr0 = spr0;
    r.ovf = ovf;
    return r;
  endfunction

  function automatic request_t random_request();
    return make_request(vdts_pkg::cmd_t'(2'($urandom_range(3))), 3'($urandom_range(7)),
                        8'($urandom_range(255)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
  endfunction

  // Mostly ticks; keep rendering and vblank alive most of the time.
  function automatic request_t sweep_request();
    request_t r;
    r = make_request(vdts_pkg::CMD_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
                     $urandom_range(15) == 0, $urandom_range(15) == 0);
    if (pos_line == vdts_pkg::LINE_PRE && pos_dot == 9'd0) begin
      r.spr0 = 1'b1;
      r.ovf = 1'b1;
    end
    if ($urandom_range(63) == 0) begin
      r.cmd = ($urandom_range(3) == 0) ? vdts_pkg::CMD_READ : vdts_pkg::CMD_WRITE;
      if (r.cmd == vdts_pkg::CMD_READ && r.idx == vdts_pkg::REG_STATUS &&
          $urandom_range(3) != 0)
        r.idx = vdts_pkg::REG_DATA;
      if (r.cmd == vdts_pkg::CMD_WRITE && r.idx == vdts_pkg::REG_MASK &&
          r.wdata[4:3] == 2'b00 && $urandom_range(15) != 0)
        r.wdata[3] = 1'b1;
    end else if ($urandom_range(511) == 0) begin
      r.cmd = vdts_pkg::CMD_NONE;
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, r.ovf, r.spr0, r.wdata};
    in_tuser <= {r.idx, r.cmd};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    predict_status(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0)
      @(posedge clk);
  endtask

  task automatic load_nmi_delay(input logic [4:0] d);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    nmi_delay_q = d;
  endtask

  task automatic test_directed();
    send_request(make_request(vdts_pkg::CMD_NONE, vdts_pkg::REG_DATA, 8'hFF, 1'b1, 1'b1));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_STATUS, 8'hFF, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_OAM_ADDR, 8'h00,
                              1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_OAM_DATA, 8'h15,
                              1'b0, 1'b0));
    for (int i = 0; i < 8; i++)
      send_request(make_request(vdts_pkg::CMD_READ, 3'(i), 8'h00, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_CTRL, 8'h87, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_DATA, 8'hFF, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_SCROLL, 8'hFF, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_SCROLL, 8'h00, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_ADDR, 8'h3F, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_ADDR, 8'hFF, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_DATA, 8'h00, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_MASK, 8'h18, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_TICK, 3'd0, 8'h00, 1'b1, 1'b1));
    send_request(make_request(vdts_pkg::CMD_TICK, 3'd0, 8'h00, 1'b0, 1'b0));
    // Hold in vblank until the NMI countdown expires.
    for (int i = 0; i < 16; i++)
      send_request(make_request(vdts_pkg::CMD_TICK, 3'd0, 8'h00, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_READ, vdts_pkg::REG_STATUS, 8'h00, 1'b0, 1'b0));
  endtask

  task automatic test_random_mix();
    for (int c = 0; c < 4; c++) begin
      case (c)
        0: load_nmi_delay(5'd1);
        1: load_nmi_delay(5'd31);
        2: load_nmi_delay(5'd0);
        default: load_nmi_delay(5'($urandom_range(31)));
      endcase
      no_idle = (c == 1);
      for (int i = 0; i < MIX_CHUNK; i++)
        send_request(random_request());
    end
    no_idle = 1'b0;
  endtask

  // Run mostly ticks with rendering and NMI enabled.
  task automatic test_tick_sweep();
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_MASK, 8'h18, 1'b0, 1'b0));
    send_request(make_request(vdts_pkg::CMD_WRITE, vdts_pkg::REG_CTRL, 8'h80, 1'b0, 1'b0));
    for (int n = 0; n < SWEEP_ITEMS; n++) begin
      if (n == SWEEP_ITEMS / 2)
        load_nmi_delay(5'd1);
      no_idle = (n < SWEEP_ITEMS / 2);
      send_request(sweep_request());
    end
    no_idle = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input dot_status_t got);
    dot_status_t want;
    if (expected_status.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      mismatch_count++;
    end else begin
      want = expected_status.pop_front();
      compare_field("rdata", 16'(want.rdata), 16'(got.rdata));
      compare_field("vram_addr", want.vram_addr, got.vram_addr);
      compare_field("fine_scroll_x", 16'(want.fine_x), 16'(got.fine_x));
      compare_field("dot", 16'(want.dot), 16'(got.dot));
      compare_field("line", 16'(want.line), 16'(got.line));
      compare_field("odd_frame", 16'(want.odd_frame), 16'(got.odd_frame));
      compare_field("nmi_pulse", 16'(want.nmi_pulse), 16'(got.nmi_pulse));
      compare_field("rendering_on", 16'(want.rendering_on), 16'(got.rendering_on));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_result(dot_status_t'(out_tdata));
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** video_dot_timing_scroll_regs: FAILED **");
    $finish;
  end

  initial begin
    reset_model();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix();
    test_tick_sweep();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("** video_dot_timing_scroll_regs: PASSED **");
    else
      $display("** video_dot_timing_scroll_regs: FAILED **");
    $finish;
  end

endmodule
